@@ sv/oldq_pkg.sv @@
// Package for the ordered list with value delete: operation and status codes, FSM states.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package oldq_pkg;
  typedef enum logic [2:0] {
    OP_PUSH_BACK  = 3'd0,
    OP_PUSH_FRONT = 3'd1,
    OP_POP_FRONT  = 3'd2,
    OP_POP_BACK   = 3'd3,
    OP_DELETE     = 3'd4,
    OP_DUMP       = 3'd5
  } op_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_EMPTY     = 2'd1,
    ST_NOT_FOUND = 2'd2,
    ST_FULL      = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_MOVE,
    S_DONE
  } state_e;
endpackage
`default_nettype wire

@@ sv/oldq_ram.sv @@
// Generic single-port-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
module oldq_ram #(
  parameter int Width = 32,
  parameter int Depth = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) mem[waddr_i] <= wdata_i;
    rdata_o <= mem[raddr_i];
  end
endmodule
`default_nettype wire

@@ sv/ordered_list_with_value_delete.sv @@
// Ordered list (bounded deque) with delete by value; top level.
// Depends on oldq_pkg and oldq_ram.
//
// Entries live in a circular buffer in one RAM with a head pointer and a count.
// A push, and any operation on an empty list, answers with one result strobe in
// the cycle after acceptance; busy stays low, so the next transfer can follow
// at once. Pops go through the RAM read port: busy is high through S_READ,
// S_MOVE and S_DONE, and the result comes with S_DONE. Delete makes one pass
// front to back, one entry a cycle, and moves the entries behind a match forward
// in the same pass; busy stays high until the pass ends, and the result comes in
// the last busy cycle. Dump emits one result per cycle, busy staying high until
// the last of them. Results carry a strobe valid_o for one cycle; the receiver
// cannot stall. Unused operation codes give no result.
`timescale 1ns / 1ps
`default_nettype none
module ordered_list_with_value_delete #(
  parameter int DEPTH = 16
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               start,
  output logic                    busy,
  input  wire logic [2:0]         operation_i,
  input  wire logic signed [31:0] item_value_i,
  output logic                    valid_o,
  output logic [1:0]              status_o,
  output logic signed [31:0]      result_value_o,
  output logic                    last_o
);
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [CW-1:0] DepthC = CW'(DEPTH);

  oldq_pkg::state_e state_q, state_d;
  logic [AW-1:0] head_q, head_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [CW-1:0] idx_q, idx_d;      // walk position, relative to head
  logic [2:0]    op_q, op_d;
  logic [31:0]   val_q, val_d;
  logic          mv_q, mv_d;        // delete: moving tail forward

  logic          we;
  logic [AW-1:0] waddr, raddr;
  logic [31:0]   wdata, rdata;

  logic          ov_d, ol_d;
  logic [1:0]    os_d;
  logic [31:0]   ovl_d;

  // circular address: head + offset, wraps at DEPTH
  function automatic logic [AW-1:0] wrap(input logic [AW-1:0] h, input logic [CW-1:0] off);
    logic [CW:0] s;
    s = {{(CW+1-AW){1'b0}}, h} + {1'b0, off};
    if (s >= (CW+1)'(DEPTH)) s = s - (CW+1)'(DEPTH);
    return s[AW-1:0];
  endfunction

  oldq_ram #(.Width(32), .Depth(DEPTH)) u_ram (
    .clk_i, .we_i(we), .waddr_i(waddr), .wdata_i(wdata), .raddr_i(raddr), .rdata_o(rdata)
  );

  // control FSM
  always_comb begin
    state_d = state_q; head_d = head_q; cnt_d = cnt_q; idx_d = idx_q;
    op_d = op_q; val_d = val_q; mv_d = mv_q;
    we = 1'b0; waddr = '0; wdata = val_q; raddr = wrap(head_q, idx_q);
    ov_d = 1'b0; ol_d = 1'b1; os_d = oldq_pkg::ST_OK; ovl_d = '0;
    unique case (state_q)
      oldq_pkg::S_IDLE: begin
        if (start) begin
          op_d = operation_i; val_d = item_value_i; idx_d = '0; mv_d = 1'b0;
          priority case (operation_i)
            oldq_pkg::OP_PUSH_BACK, oldq_pkg::OP_PUSH_FRONT: begin
              ov_d = 1'b1;
              if (cnt_q >= DepthC) os_d = oldq_pkg::ST_FULL;
              else if (operation_i == oldq_pkg::OP_PUSH_BACK) begin
                we = 1'b1; waddr = wrap(head_q, cnt_q); wdata = item_value_i;
                cnt_d = cnt_q + 1'b1;
              end else begin
                head_d = wrap(head_q, DepthC - 1'b1);
                we = 1'b1; waddr = head_d; wdata = item_value_i;
                cnt_d = cnt_q + 1'b1;
              end
            end
            oldq_pkg::OP_POP_FRONT, oldq_pkg::OP_POP_BACK,
            oldq_pkg::OP_DELETE, oldq_pkg::OP_DUMP: begin
              if (cnt_q == '0) begin
                ov_d = 1'b1; os_d = oldq_pkg::ST_EMPTY;
              end else begin
                if (operation_i == oldq_pkg::OP_POP_BACK) idx_d = cnt_q - 1'b1;
                state_d = oldq_pkg::S_READ;
              end
            end
            default: ;
          endcase
        end
      end
      oldq_pkg::S_READ: begin
        // address presented; data next cycle
        state_d = oldq_pkg::S_MOVE;
        if (op_q == oldq_pkg::OP_DUMP || op_q == oldq_pkg::OP_DELETE)
          idx_d = idx_q + 1'b1;
      end
      oldq_pkg::S_MOVE: begin
        // rdata holds entry at idx_q-1 (dump/delete) or idx_q (pops)
        priority case (op_q)
          oldq_pkg::OP_POP_FRONT: begin
            ov_d = 1'b1; ovl_d = rdata;
            head_d = wrap(head_q, CW'(1)); cnt_d = cnt_q - 1'b1;
            state_d = oldq_pkg::S_DONE;
          end
          oldq_pkg::OP_POP_BACK: begin
            ov_d = 1'b1; ovl_d = rdata; cnt_d = cnt_q - 1'b1;
            state_d = oldq_pkg::S_DONE;
          end
          oldq_pkg::OP_DUMP: begin
            ov_d = 1'b1; ovl_d = rdata; ol_d = (idx_q == cnt_q);
            if (idx_q == cnt_q) state_d = oldq_pkg::S_DONE;
            else idx_d = idx_q + 1'b1;
          end
          default: begin
            if (!mv_q) begin
              if (rdata == val_q) begin
                mv_d = 1'b1;
                if (idx_q == cnt_q) begin
                  cnt_d = cnt_q - 1'b1; ov_d = 1'b1; ovl_d = val_q;
                  state_d = oldq_pkg::S_DONE;
                end else idx_d = idx_q + 1'b1;
              end else if (idx_q == cnt_q) begin
                ov_d = 1'b1; os_d = oldq_pkg::ST_NOT_FOUND;
                state_d = oldq_pkg::S_DONE;
              end else idx_d = idx_q + 1'b1;
            end else begin
              // copy entry idx_q-1 to idx_q-2
              we = 1'b1; waddr = wrap(head_q, idx_q - 2'd2); wdata = rdata;
              if (idx_q == cnt_q) begin
                cnt_d = cnt_q - 1'b1; ov_d = 1'b1; ovl_d = val_q;
                state_d = oldq_pkg::S_DONE;
              end else idx_d = idx_q + 1'b1;
            end
          end
        endcase
      end
      oldq_pkg::S_DONE: state_d = oldq_pkg::S_IDLE;
      default: state_d = oldq_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= oldq_pkg::S_IDLE; head_q <= '0; cnt_q <= '0; valid_o <= 1'b0;
    end else begin
      state_q <= state_d; head_q <= head_d; cnt_q <= cnt_d; valid_o <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q <= idx_d; op_q <= op_d; val_q <= val_d; mv_q <= mv_d;
    status_o <= os_d; result_value_o <= ovl_d; last_o <= ol_d;
  end

  assign busy = (state_q != oldq_pkg::S_IDLE);

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni) cnt_q <= DepthC)
    else $error("entry count over depth");
  a_busy_on_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy && operation_i == oldq_pkg::OP_DUMP && cnt_q != '0 |=> busy)
    else $error("dump did not raise busy");
  a_idle_after_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == oldq_pkg::S_DONE |=> !busy)
    else $error("did not return idle");
  a_ok_nonfull_push: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && status_o == oldq_pkg::ST_FULL |-> cnt_q == DepthC)
    else $error("full status with room");
endmodule
`default_nettype wire
